// ----- rtl/psra_pkg.sv -----
// Shared types, sizes and codes for the per-sensor running average alarm.
`default_nettype none
package psra_pkg;
    localparam int SLOTS  = 64;
    localparam int WINDOW = 5;

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int SAMP_AW = (SLOTS * WINDOW > 1) ? $clog2(SLOTS * WINDOW) : 1;
    localparam int NXT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int META_W  = NXT_W + FILL_W;
    localparam int SUM_W   = 16 + $clog2(WINDOW);
    localparam int MAG_W   = SUM_W;
    localparam int REM_W   = FILL_W + 1;
    localparam int DCNT_W  = $clog2(MAG_W);

    localparam logic [1:0] ST_NORMAL  = 2'd0;
    localparam logic [1:0] ST_COLD    = 2'd1;
    localparam logic [1:0] ST_HOT     = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic CFG_COLD = 1'b0;
    localparam logic CFG_HOT  = 1'b1;

    localparam logic signed [15:0] COLD_RESET = 16'sd3840;
    localparam logic signed [15:0] HOT_RESET  = 16'sd6400;

    typedef struct packed {
        logic        [15:0] probe_id;
        logic signed [15:0] temperature;
    } t_in_beat;

    typedef struct packed {
        logic        [15:0] sensor_echo;
        logic signed [15:0] average;
        logic        [1:0]  status;
    } t_out_beat;

    typedef struct packed {
        logic load_in;
        logic idx_inc;
        logic meta_rd;
        logic meta_load;
        logic claim;
        logic res_full;
        logic wr_sample;
        logic acc_add;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic hit;
        logic idx_last;
        logic k_last;
        logic div_last;
        logic out_free;
    } t_sts;
endpackage
`default_nettype wire

// ----- rtl/psra_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module psra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/psra_ctrl.sv -----
// Sequencer: slot search, claim, window update, sum, divide and result hand-off.
`default_nettype none
module psra_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire psra_pkg::t_sts i_sts,
    output psra_pkg::t_cmd      o_cmd
);
    import psra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SRD, S_SCMP, S_NEW, S_META, S_WRS,
        S_ARD, S_AADD, S_DIVS, S_DIV, S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_sts.empty ? S_NEW : S_SRD;
                end
            end
            S_SRD: n_state = S_SCMP;
            S_SCMP: begin
                if (i_sts.hit) begin
                    o_cmd.meta_rd = 1'b1;
                    n_state = S_META;
                end else if (i_sts.idx_last) begin
                    n_state = S_NEW;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_SRD;
                end
            end
            S_NEW: begin
                if (i_sts.full) begin
                    o_cmd.res_full = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.claim = 1'b1;
                    n_state = S_WRS;
                end
            end
            S_META: begin
                o_cmd.meta_load = 1'b1;
                n_state = S_WRS;
            end
            S_WRS: begin
                o_cmd.wr_sample = 1'b1;
                n_state = S_ARD;
            end
            S_ARD: n_state = S_AADD;
            S_AADD: begin
                o_cmd.acc_add = 1'b1;
                n_state = i_sts.k_last ? S_DIVS : S_ARD;
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/psra_dp.sv -----
// Datapath: slot tables, sample window, accumulator, divider and result register.
`default_nettype none
module psra_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire psra_pkg::t_cmd      i_cmd,
    output psra_pkg::t_sts           o_sts,
    input  wire psra_pkg::t_in_beat  i_in_data,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [15:0]         i_cfg_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output psra_pkg::t_out_beat      o_out_data
);
    import psra_pkg::*;

    logic        [15:0]       r_id;
    logic signed [15:0]       r_temp;
    logic        [SLOT_W-1:0] r_idx;
    logic        [CNT_W-1:0]  r_used;
    logic        [SLOT_W-1:0] r_slot;
    logic        [FILL_W-1:0] r_fill;
    logic        [NXT_W-1:0]  r_next;
    logic        [NXT_W-1:0]  r_k;
    logic signed [SUM_W-1:0]  r_sum;
    logic        [REM_W-1:0]  r_rem;
    logic        [MAG_W-1:0]  r_quo;
    logic                     r_neg;
    logic        [DCNT_W-1:0] r_dcnt;
    logic                     r_unk;
    logic signed [15:0]       r_cold;
    logic signed [15:0]       r_hot;
    logic                     r_out_valid;
    t_out_beat                r_out;

    logic        [15:0]        sens_rdata;
    logic        [META_W-1:0]  meta_rdata;
    logic        [15:0]        samp_rdata;
    logic signed [15:0]        samp_val;
    logic        [SAMP_AW-1:0] base;
    logic        [NXT_W-1:0]   n_next;
    logic        [FILL_W-1:0]  n_fill;
    logic        [REM_W-1:0]   trial;
    logic        [REM_W-1:0]   divisor;
    logic                      qbit;
    logic signed [15:0]        mean;
    logic        [MAG_W-1:0]   mag;

    psra_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_sens (
        .i_clk   (i_clk),
        .i_we    (i_cmd.claim),
        .i_waddr (r_used[SLOT_W-1:0]),
        .i_wdata (r_id),
        .i_raddr (r_idx),
        .o_rdata (sens_rdata)
    );

    psra_ram #(.WIDTH(META_W), .DEPTH(SLOTS)) u_meta (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_sample),
        .i_waddr (r_slot),
        .i_wdata ({n_next, n_fill}),
        .i_raddr (r_idx),
        .o_rdata (meta_rdata)
    );

    psra_ram #(.WIDTH(16), .DEPTH(SLOTS * WINDOW)) u_samp (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_sample),
        .i_waddr (base + SAMP_AW'(r_next)),
        .i_wdata (r_temp),
        .i_raddr (base + SAMP_AW'(r_k)),
        .o_rdata (samp_rdata)
    );

    always_comb begin
        base     = SAMP_AW'(r_slot) * SAMP_AW'(WINDOW);
        n_next   = (r_next == NXT_W'(WINDOW - 1)) ? '0 : r_next + NXT_W'(1);
        n_fill   = (r_fill == FILL_W'(WINDOW)) ? r_fill : r_fill + FILL_W'(1);
        samp_val = samp_rdata;
        mag      = r_sum[SUM_W-1] ? MAG_W'(-r_sum) : MAG_W'(r_sum);
        trial    = {r_rem[REM_W-2:0], r_quo[MAG_W-1]};
        divisor  = REM_W'(r_fill);
        qbit     = (trial >= divisor);
        mean     = r_neg ? -$signed(r_quo[15:0]) : $signed(r_quo[15:0]);
    end

    always_comb begin
        o_sts.empty    = (r_used == '0);
        o_sts.full     = (r_used == CNT_W'(SLOTS));
        o_sts.hit      = (sens_rdata == r_id);
        o_sts.idx_last = (CNT_W'(r_idx) + CNT_W'(1) == r_used);
        o_sts.k_last   = (FILL_W'(r_k) + FILL_W'(1) == r_fill);
        o_sts.div_last = (r_dcnt == DCNT_W'(MAG_W - 1));
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_id   <= i_in_data.probe_id;
            r_temp <= i_in_data.temperature;
            r_idx  <= '0;
            r_unk  <= 1'b0;
        end
        if (i_cmd.idx_inc) begin
            r_idx <= r_idx + SLOT_W'(1);
        end
        if (i_cmd.meta_rd) begin
            r_slot <= r_idx;
        end
        if (i_cmd.meta_load) begin
            {r_next, r_fill} <= meta_rdata;
        end
        if (i_cmd.claim) begin
            r_slot <= r_used[SLOT_W-1:0];
            r_next <= '0;
            r_fill <= '0;
        end
        if (i_cmd.res_full) begin
            r_unk <= 1'b1;
        end
        if (i_cmd.wr_sample) begin
            r_next <= n_next;
            r_fill <= n_fill;
            r_k    <= '0;
            r_sum  <= '0;
        end
        if (i_cmd.acc_add) begin
            r_sum <= r_sum + SUM_W'(samp_val);
            r_k   <= r_k + NXT_W'(1);
        end
        if (i_cmd.div_start) begin
            r_neg  <= r_sum[SUM_W-1];
            r_quo  <= mag;
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= qbit ? trial - divisor : trial;
            r_quo  <= {r_quo[MAG_W-2:0], qbit};
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out.sensor_echo <= r_id;
            if (r_unk) begin
                r_out.average <= '0;
                r_out.status  <= ST_UNKNOWN;
            end else begin
                r_out.average <= mean;
                if (mean < r_cold) begin
                    r_out.status <= ST_COLD;
                end else if (mean > r_hot) begin
                    r_out.status <= ST_HOT;
                end else begin
                    r_out.status <= ST_NORMAL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_cold      <= COLD_RESET;
            r_hot       <= HOT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.claim) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COLD: r_cold <= i_cfg_data;
                    CFG_HOT:  r_hot  <= i_cfg_data;
                    default:  r_cold <= r_cold;
                endcase
            end
            // load wins over a beat taken in the same cycle
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

// ----- rtl/per_sensor_running_average_alarm.sv -----
// Top level of the per-sensor running average alarm.
// Each reading is matched against the slot table by a linear scan of the used
// slots through the registered sensor-ID RAM read, an unknown ID claims the
// next free slot, the reading goes into that slot's window, the held readings
// are summed one at a time from the sample RAM, each read before it is added,
// and the sum is divided by the count in a 19-step restoring divider. A match
// at slot j scans j+1 slots, and a new ID or a reading that finds the table
// full scans every used slot. A result that waits in the output register
// stalls the next result until it is taken. One reading is in work at a time,
// and the next beat is taken while the finished result still waits in the
// output register. Slots are never freed; once all 64 are used, an unknown ID
// returns average 0 and status 3.
`default_nettype none
module per_sensor_running_average_alarm (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire psra_pkg::t_in_beat  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output psra_pkg::t_out_beat      o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [15:0]         i_cfg_data
);
    import psra_pkg::*;

    t_cmd cmd;
    t_sts sts;

    psra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    psra_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );
endmodule
`default_nettype wire

// ----- tb/sv/tb_per_sensor_running_average_alarm.sv -----
// Testbench for the per-sensor running average alarm: queued stimulus, scoreboard check.
`default_nettype none
module tb_per_sensor_running_average_alarm;
    import psra_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_beat i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_beat o_out_data;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [15:0] i_cfg_data = '0;

    per_sensor_running_average_alarm dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // predictor state
    logic signed [15:0] cold_lim, hot_lim;
    logic               tbl_used [SLOTS];
    logic [15:0]        tbl_id [SLOTS];
    logic signed [15:0] tbl_ring [SLOTS][WINDOW];
    int                 tbl_fill [SLOTS];
    int                 tbl_next [SLOTS];

    t_in_beat  pending_beats[$];
    t_out_beat expected_avgs[$];
    int  errors = 0;
    int  cycles = 0;
    int  accepted = 0;
    int  checked = 0;
    bit  quiet = 1'b0;   // no idling when set
    int  in_gap = 0, out_gap = 0;

    function automatic t_out_beat predict_average(t_in_beat b);
        t_out_beat r;
        int s, sum, mean;
        s = -1;
        r.sensor_echo = b.probe_id;
        for (int i = 0; i < SLOTS; i++)
            if (s < 0 && tbl_used[i] && tbl_id[i] == b.probe_id) s = i;
        if (s < 0)
            for (int i = 0; i < SLOTS; i++)
                if (s < 0 && !tbl_used[i]) begin
                    s = i;
                    tbl_used[i] = 1'b1;
                    tbl_id[i] = b.probe_id;
                    tbl_fill[i] = 0;
                    tbl_next[i] = 0;
                end
        if (s < 0) begin
            r.average = '0;
            r.status = ST_UNKNOWN;
            return r;
        end
        tbl_ring[s][tbl_next[s]] = b.temperature;
        tbl_next[s] = (tbl_next[s] + 1) % WINDOW;
        if (tbl_fill[s] < WINDOW) tbl_fill[s]++;
        sum = 0;
        for (int k = 0; k < tbl_fill[s]; k++) sum += tbl_ring[s][k];
        mean = sum / tbl_fill[s];
        r.average = mean[15:0];
        if (mean < cold_lim) r.status = ST_COLD;
        else if (mean > hot_lim) r.status = ST_HOT;
        else r.status = ST_NORMAL;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_in_valid && o_in_ready) begin
            expected_avgs.push_back(predict_average(i_in_data));
            accepted <= accepted + 1;
        end
        if (!i_in_valid || o_in_ready) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_beats.size() > 0 && i_rst_n) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_beats.pop_front();
                if (!quiet && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 19);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_beat e;
        int bad;
        bad = 0;
        if (o_out_valid && i_out_ready) begin
            checked <= checked + 1;
            if (expected_avgs.size() == 0) begin
                bad = 1;
                $display("%0t unexpected beat: expected none, actual %h", $time, o_out_data);
            end else begin
                e = expected_avgs.pop_front();
                if (o_out_data.sensor_echo !== e.sensor_echo) begin
                    bad++;
                    $display("%0t sensor_echo: expected %h, actual %h", $time,
                             e.sensor_echo, o_out_data.sensor_echo);
                end
                if (o_out_data.average !== e.average) begin
                    bad++;
                    $display("%0t average: expected %0d, actual %0d", $time,
                             e.average, o_out_data.average);
                end
                if (o_out_data.status !== e.status) begin
                    bad++;
                    $display("%0t status: expected %0d, actual %0d", $time,
                             e.status, o_out_data.status);
                end
            end
        end
        if (bad > 0) begin
            errors <= errors + bad;
        end
        if (quiet) begin
            i_out_ready <= 1'b1;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            out_gap <= $urandom_range(1, 19) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_beat(input logic [15:0] id, input logic [15:0] t);
        t_in_beat b;
        b.probe_id = id;
        b.temperature = t;
        pending_beats.push_back(b);
    endtask

    // wait for every beat to be handled, then for the block to settle
    task automatic drain();
        while (pending_beats.size() > 0 || i_in_valid || expected_avgs.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic idx, input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        if (idx == CFG_COLD) cold_lim = v;
        else hot_lim = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random readings over a known id pool, sometimes near the limits
    task automatic random_phase(input int n, input logic [15:0] id_base, input int pool);
        logic [15:0] t;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: t = 16'($urandom);
                1: t = 16'(16'h8000 + $urandom_range(0, 3));
                2: t = 16'(16'h7FFF - $urandom_range(0, 3));
                default: t = $signed(cold_lim) + $signed(16'($urandom_range(0, 3000)));
            endcase
            add_beat(id_base + 16'($urandom_range(0, pool - 1)), t);
        end
    endtask

    initial begin
        cold_lim = COLD_RESET;
        hot_lim = HOT_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_used[i] = 1'b0;
            tbl_id[i] = '0;
            tbl_fill[i] = 0;
            tbl_next[i] = 0;
            for (int k = 0; k < WINDOW; k++) tbl_ring[i][k] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, wrap of the window, equal-to-limit, id extremes
        add_beat(16'h0000, 16'h7FFF);
        add_beat(16'hFFFF, 16'h8000);
        for (int i = 0; i < 6; i++) add_beat(16'h0000, 16'h7FFF);
        for (int i = 0; i < 6; i++) add_beat(16'hFFFF, 16'h8000);
        add_beat(16'h1234, 16'd3840);
        add_beat(16'h1235, 16'd6400);
        add_beat(16'h1236, 16'd3839);
        add_beat(16'h1237, 16'd6401);
        add_beat(16'h1238, -16'sd3);
        add_beat(16'h1238, 16'sd1);
        drain();

        // crossed limits: cold above hot
        write_limit(CFG_COLD, 16'd6400);
        write_limit(CFG_HOT, 16'd3840);
        add_beat(16'h2000, 16'd5000);
        add_beat(16'h2001, 16'd100);
        add_beat(16'h2002, 16'd7000);
        random_phase(400, 16'h4000, 24);
        drain();

        write_limit(CFG_COLD, 16'h8000);
        write_limit(CFG_HOT, 16'h7FFF);
        random_phase(400, 16'h5000, 20);
        drain();

        write_limit(CFG_COLD, 16'h7FFF);
        write_limit(CFG_HOT, 16'h8000);
        random_phase(300, 16'h6000, 12);
        drain();

        // fill the table, then probe unknown ids and known ones
        write_limit(CFG_COLD, 16'hFF00);
        write_limit(CFG_HOT, 16'h0100);
        for (int i = 0; i < 80; i++) add_beat(16'($urandom), 16'($urandom));
        random_phase(300, 16'h4000, 40);
        drain();

        quiet = 1'b1;
        write_limit(CFG_COLD, COLD_RESET);
        write_limit(CFG_HOT, HOT_RESET);
        random_phase(400, 16'h5000, 20);
        drain();

        $display("Handled %0d readings, checked %0d results over six limit settings",
                 accepted, checked);
        $display("including full table, crossed and extreme limits");
        if (errors == 0 && expected_avgs.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
